### design/irig_pkg.sv
// shared types, constants and helper functions for the irig-b frame generator
`default_nettype none

package irig_pkg;

  localparam int FrameLen = 100;
  localparam int NumSlots = 11;
  localparam int SodBits  = 17;

  localparam logic [6:0] LastSym = 7'(FrameLen - 1);
  localparam logic [3:0] LastSub = 4'd9;

  // straight-binary seconds-of-day bits, split around the marker at 89
  localparam logic [6:0] SodLoAt  = 7'd80;
  localparam logic [6:0] SodLoEnd = 7'd88;
  localparam logic [6:0] SodHiAt  = 7'd90;
  localparam logic [6:0] SodHiEnd = 7'd97;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    SYM_ZERO = 2'd0,
    SYM_ONE  = 2'd1,
    SYM_MARK = 2'd2,
    SYM_ERR  = 2'd3
  } sym_e;

  // bcd slots: sec ones/tens, min ones/tens, hour ones/tens,
  // day ones/tens/hundreds, year ones/tens
  localparam logic [6:0] SlotAt [NumSlots] = '{
    7'd1, 7'd6, 7'd10, 7'd15, 7'd20, 7'd25, 7'd30, 7'd35, 7'd40, 7'd50, 7'd55
  };
  localparam logic [2:0] SlotLen [NumSlots] = '{
    3'd4, 3'd3, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd4, 3'd2, 3'd4, 3'd4
  };

  // days before each month, by month code
  localparam logic [8:0] MonthOffset [16] = '{
    9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd365, 9'd365
  };

  // high sub-slots per symbol code
  localparam logic [3:0] HighCount [4] = '{4'd2, 4'd5, 4'd8, 4'd10};

  function automatic logic [127:0] mark_mask();
    logic [127:0] m;
    m = '0;
    m[0] = 1'b1;
    for (int i = 9; i < FrameLen; i += 10) m[i] = 1'b1;
    return m;
  endfunction

  localparam logic [127:0] MarkMask = mark_mask();

  // x / 10 for x below 1024
  function automatic logic [6:0] div10_n(input logic [9:0] x);
    logic [17:0] p;
    p = {8'b0, x} * 18'd205;
    return p[17:11];
  endfunction

  // x / 10 for any 14-bit x
  function automatic logic [10:0] div10_w(input logic [13:0] x);
    logic [29:0] p;
    p = {16'b0, x} * 30'd52429;
    return p[29:19];
  endfunction

  typedef struct packed {
    op_e         op;
    logic [5:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } in_item_t;

  typedef struct packed {
    op_e         op;
    logic [6:0]  sec;
    logic [3:0]  sec_q;
    logic [6:0]  min;
    logic [3:0]  min_q;
    logic [5:0]  hour;
    logic [2:0]  hour_q;
    logic [8:0]  doy;
    logic [13:0] year;
    logic [10:0] year_q;
    logic [17:0] hour_sec;
    logic [12:0] min_sec;
  } mid_t;

  typedef struct packed {
    logic       err;
    logic [3:0] digit;
  } slot_t;

  typedef struct packed {
    slot_t [NumSlots-1:0] slots;
    logic [SodBits-1:0]   sod;
  } frame_upd_t;

  typedef struct packed {
    logic level;
    logic symbol_start;
    logic frame_end;
  } out_item_t;

endpackage

`default_nettype wire

### design/irig_b_frame_generator.sv
// top level of the irig-b frame generator: handshakes, pipeline and result register
`default_nettype none

// irig-b frame generator. a load item (opcode 0) rebuilds the 100-symbol
// frame from hour, minute, second, year, month and day: bcd digits of the
// time, day of year and two year digits, plus 17 straight-binary
// seconds-of-day bits at symbols 80-88 and 90-97; markers and index symbols
// stay at their fixed places. a digit that is not bcd or that overflows its
// slot is sent as error symbols over the whole slot. a tick item (opcode 1)
// plays the next of ten sub-slots of the current symbol and gives one result
// item; a load gives none and does not move the play position. one item is
// taken every cycle while the pipe is not held; an item passes an input
// register, a middle register and, for ticks, the result register. the
// two-register path is set by the load math (constant divides by ten and
// the seconds-of-day products), split across the input and middle stages;
// the frame is read and written in the middle stage, so items take effect
// strictly in order. the result register frees the input side while a
// result waits: only a tick meeting a full, stalled result register holds
// the pipe.
module irig_b_frame_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [5:0]  hour_value_i,
  input  logic [6:0]  minute_value_i,
  input  logic [6:0]  second_value_i,
  input  logic [13:0] year_value_i,
  input  logic [3:0]  month_value_i,
  input  logic [4:0]  day_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        level_o,
  output logic        symbol_start_o,
  output logic        frame_end_o
);
  import irig_pkg::*;

  // pipeline registers
  logic      in_vld_q, in_vld_d;
  in_item_t  in_q;
  logic      mid_vld_q, mid_vld_d;
  mid_t      mid_q;
  mid_t      mid_d;
  logic      out_vld_q, out_vld_d;
  out_item_t out_q;

  // handshake and stage control
  logic in_fire, s1_fire, s2_fire, s2_ready, out_free, tick_fire, load_fire;

  frame_upd_t upd;
  sym_e       code;
  logic [6:0] sym_pos;
  out_item_t  res;

  // a load never waits on the result side, a tick needs the result slot
  assign out_free  = !out_vld_q || out_ready_i;
  assign s2_fire   = mid_vld_q && ((mid_q.op == OP_LOAD) || out_free);
  assign s2_ready  = !mid_vld_q || s2_fire;
  assign s1_fire   = in_vld_q && s2_ready;
  assign in_ready_o = !in_vld_q || s1_fire;
  assign in_fire   = in_valid_i && in_ready_o;
  assign tick_fire = s2_fire && (mid_q.op == OP_TICK);
  assign load_fire = s2_fire && (mid_q.op == OP_LOAD);

  always_comb begin
    in_vld_d  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : in_vld_q);
    mid_vld_d = s1_fire ? 1'b1 : (s2_fire ? 1'b0 : mid_vld_q);
    out_vld_d = tick_fire ? 1'b1 : (out_ready_i ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      mid_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      mid_vld_q <= mid_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q.op     <= op_e'(opcode_i);
      in_q.hour   <= hour_value_i;
      in_q.minute <= minute_value_i;
      in_q.second <= second_value_i;
      in_q.year   <= year_value_i;
      in_q.month  <= month_value_i;
      in_q.day    <= day_value_i;
    end
    if (s1_fire)   mid_q <= mid_d;
    if (tick_fire) out_q <= res;
  end

  // input stage: quotients, day of year, time products
  irig_calc_front u_front (
    .item_i (in_q),
    .mid_o  (mid_d)
  );

  // middle stage: digits and checks for a load
  irig_calc_back u_back (
    .mid_i (mid_q),
    .upd_o (upd)
  );

  // frame contents, written by a load in the middle stage
  irig_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (load_fire),
    .upd_i     (upd),
    .sym_pos_i (sym_pos),
    .code_o    (code)
  );

  // play position, moved by a tick in the middle stage
  irig_player u_player (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (tick_fire),
    .code_i    (code),
    .sym_pos_o (sym_pos),
    .res_o     (res)
  );

  assign out_valid_o    = out_vld_q;
  assign level_o        = out_q.level;
  assign symbol_start_o = out_q.symbol_start;
  assign frame_end_o    = out_q.frame_end;

endmodule

`default_nettype wire

### design/irig_calc_front.sv
// first half of the load math: quotients, day of year, time products
`default_nettype none

module irig_calc_front (
  input  irig_pkg::in_item_t item_i,
  output irig_pkg::mid_t     mid_o
);
  import irig_pkg::*;

  logic [6:0] sec_q7, min_q7, hour_q7;
  logic       leap;

  always_comb begin
    sec_q7  = div10_n({3'b000, item_i.second});
    min_q7  = div10_n({3'b000, item_i.minute});
    hour_q7 = div10_n({4'b0000, item_i.hour});
    leap    = (item_i.year[1:0] == 2'b00) && (item_i.month > 4'd2);

    mid_o.op       = item_i.op;
    mid_o.sec      = item_i.second;
    mid_o.sec_q    = sec_q7[3:0];
    mid_o.min      = item_i.minute;
    mid_o.min_q    = min_q7[3:0];
    mid_o.hour     = item_i.hour;
    mid_o.hour_q   = hour_q7[2:0];
    mid_o.doy      = {4'b0000, item_i.day} + MonthOffset[item_i.month] + {8'b0, leap};
    mid_o.year     = item_i.year;
    mid_o.year_q   = div10_w(item_i.year);
    mid_o.hour_sec = {12'b0, item_i.hour} * 18'd3600;
    mid_o.min_sec  = {6'b0, item_i.minute} * 13'd60;
  end

endmodule

`default_nettype wire

### design/irig_calc_back.sv
// second half of the load math: bcd digits, range checks, seconds of day
`default_nettype none

module irig_calc_back (
  input  irig_pkg::mid_t       mid_i,
  output irig_pkg::frame_upd_t upd_o
);
  import irig_pkg::*;

  logic [3:0]  raw [NumSlots];
  logic [6:0]  sec_r, min_r, doy_q1f;
  logic [5:0]  hour_r, doy_q1, doy_d10;
  logic [8:0]  doy_r;
  logic [1:0]  doy_q2;
  logic [13:0] year_r;
  logic [10:0] year_q2, year_r10;
  logic [17:0] sod;

  always_comb begin
    sec_r  = mid_i.sec - ({3'b000, mid_i.sec_q} * 7'd10);
    min_r  = mid_i.min - ({3'b000, mid_i.min_q} * 7'd10);
    hour_r = mid_i.hour - ({3'b000, mid_i.hour_q} * 6'd10);

    doy_q1f = div10_n({1'b0, mid_i.doy});
    doy_q1  = doy_q1f[5:0];
    doy_r   = mid_i.doy - ({3'b000, doy_q1} * 9'd10);
    if (doy_q1 >= 6'd30)      doy_q2 = 2'd3;
    else if (doy_q1 >= 6'd20) doy_q2 = 2'd2;
    else if (doy_q1 >= 6'd10) doy_q2 = 2'd1;
    else                      doy_q2 = 2'd0;
    doy_d10 = doy_q1 - ({4'b0000, doy_q2} * 6'd10);

    year_q2  = div10_w({3'b000, mid_i.year_q});
    year_r   = mid_i.year - ({3'b000, mid_i.year_q} * 14'd10);
    year_r10 = mid_i.year_q - (year_q2 * 11'd10);

    raw[0]  = sec_r[3:0];
    raw[1]  = mid_i.sec_q;
    raw[2]  = min_r[3:0];
    raw[3]  = mid_i.min_q;
    raw[4]  = hour_r[3:0];
    raw[5]  = {1'b0, mid_i.hour_q};
    raw[6]  = doy_r[3:0];
    raw[7]  = doy_d10[3:0];
    raw[8]  = {2'b00, doy_q2};
    raw[9]  = year_r[3:0];
    raw[10] = year_r10[3:0];

    // a digit that is not bcd or overflows its slot turns the slot to errors
    for (int k = 0; k < NumSlots; k++) begin
      upd_o.slots[k].digit = raw[k];
      upd_o.slots[k].err   = (raw[k] >= 4'd10) ||
                             ({1'b0, raw[k]} >= (5'd1 << SlotLen[k]));
    end

    sod       = mid_i.hour_sec + {5'b0, mid_i.min_sec} + {11'b0, mid_i.sec};
    upd_o.sod = sod[SodBits-1:0];
  end

endmodule

`default_nettype wire

### design/irig_frame.sv
// frame contents held as loaded digits, with the symbol lookup for one position
`default_nettype none

module irig_frame (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  irig_pkg::frame_upd_t upd_i,
  input  logic [6:0]           sym_pos_i,
  output irig_pkg::sym_e       code_o
);
  import irig_pkg::*;

  slot_t [NumSlots-1:0] slots_q;
  logic [SodBits-1:0]   sod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= '0;
      sod_q   <= '0;
    end else if (wr_en_i) begin
      slots_q <= upd_i.slots;
      sod_q   <= upd_i.sod;
    end
  end

  always_comb begin
    logic [6:0] off;
    off    = '0;
    code_o = SYM_ZERO;
    if (MarkMask[sym_pos_i]) code_o = SYM_MARK;
    for (int k = 0; k < NumSlots; k++) begin
      if (sym_pos_i >= SlotAt[k] && sym_pos_i < SlotAt[k] + {4'b0000, SlotLen[k]}) begin
        off = sym_pos_i - SlotAt[k];
        if (slots_q[k].err)                code_o = SYM_ERR;
        else if (slots_q[k].digit[off[1:0]]) code_o = SYM_ONE;
        else                               code_o = SYM_ZERO;
      end
    end
    if (sym_pos_i >= SodLoAt && sym_pos_i <= SodLoEnd) begin
      off    = sym_pos_i - SodLoAt;
      code_o = sod_q[off[4:0]] ? SYM_ONE : SYM_ZERO;
    end else if (sym_pos_i >= SodHiAt && sym_pos_i <= SodHiEnd) begin
      // the high part carries bits 9 and up
      off    = sym_pos_i - SodHiAt + 7'd9;
      code_o = sod_q[off[4:0]] ? SYM_ONE : SYM_ZERO;
    end
  end

endmodule

`default_nettype wire

### design/irig_player.sv
// symbol and sub-slot counters, level and markers for the current sub-slot
`default_nettype none

module irig_player (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  irig_pkg::sym_e      code_i,
  output logic [6:0]          sym_pos_o,
  output irig_pkg::out_item_t res_o
);
  import irig_pkg::*;

  logic [6:0] sym_q, sym_d;
  logic [3:0] sub_q, sub_d;

  always_comb begin
    sym_d = sym_q;
    sub_d = sub_q;
    if (adv_i) begin
      if (sub_q == LastSub) begin
        sub_d = '0;
        sym_d = (sym_q == LastSym) ? 7'd0 : sym_q + 7'd1;
      end else begin
        sub_d = sub_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q <= '0;
      sub_q <= '0;
    end else begin
      sym_q <= sym_d;
      sub_q <= sub_d;
    end
  end

  assign sym_pos_o          = sym_q;
  assign res_o.level        = sub_q < HighCount[code_i];
  assign res_o.symbol_start = (sub_q == 4'd0);
  assign res_o.frame_end    = (sym_q == LastSym) && (sub_q == LastSub);

endmodule

`default_nettype wire

### design/irig_checker.sv
// port-level checks of the irig-b frame generator, bound to the top level
`default_nettype none

module irig_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic level_o,
  input logic symbol_start_o,
  input logic frame_end_o
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(level_o) &&
      $stable(symbol_start_o) && $stable(frame_end_o))
    else $error("result item changed while stalled");

  // every symbol code starts high
  a_start_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && symbol_start_o |-> level_o)
    else $error("symbol starts low");

  // frame end is the last sub-slot of a marker: low and not a symbol start
  a_end_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> !level_o && !symbol_start_o)
    else $error("frame end on a wrong sub-slot");

  // the sub-slot after frame end begins the marker at symbol 0
  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && frame_end_o ##1 out_valid_o |-> symbol_start_o)
    else $error("frame did not wrap to a symbol start");

endmodule

bind irig_b_frame_generator irig_checker u_irig_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .level_o        (level_o),
  .symbol_start_o (symbol_start_o),
  .frame_end_o    (frame_end_o)
);

`default_nettype wire

### dv/tb_irig_b_frame_generator.sv
// testbench for the irig-b frame generator: directed table, then random items checked by a predictor
`timescale 1ns / 100ps

module tb_irig_b_frame_generator;
  import irig_pkg::*;

  localparam int CycleLimit   = 200_000;
  localparam int PhaseItems   = 125;   // three phases plus the directed rows, about 400 items
  localparam int SettleCycles = 8;
  localparam int MaxReports   = 10;
  localparam int SubSlots     = 10;

  // days before each month, by month code; codes past twelve take the whole year
  localparam int unsigned DaysBefore [16] = '{
    0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365, 365, 365
  };

  typedef struct {
    in_item_t  item;
    bit        typed;  // want holds a hand-written result for this tick
    out_item_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        opcode_i;
  logic [5:0]  hour_value_i;
  logic [6:0]  minute_value_i;
  logic [6:0]  second_value_i;
  logic [13:0] year_value_i;
  logic [3:0]  month_value_i;
  logic [4:0]  day_value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        level_o;
  logic        symbol_start_o;
  logic        frame_end_o;

  irig_b_frame_generator i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .opcode_i,
    .hour_value_i,
    .minute_value_i,
    .second_value_i,
    .year_value_i,
    .month_value_i,
    .day_value_i,
    .out_valid_o,
    .out_ready_i,
    .level_o,
    .symbol_start_o,
    .frame_end_o
  );

  always #5 clk_i = ~clk_i;

  // predicted frame and play position
  sym_e        frame_q [FrameLen];
  int unsigned sym_pos;
  int unsigned sub_pos;

  // sub-slots still owed by the block, oldest first
  out_item_t   slots_due [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          cycles;
  int          n_errors;
  int          n_loads;
  int          n_ticks;
  int          n_wraps;
  int          n_err_slots;
  out_item_t   got;
  out_item_t   want;

  function automatic void frame_reset();
    for (int i = 0; i < FrameLen; i++)
      frame_q[i] = (i == 0 || i % 10 == 9) ? SYM_MARK : SYM_ZERO;
    sym_pos = 0;
    sub_pos = 0;
  endfunction

  // one bcd digit, lsb first; a digit that is not bcd or too wide fills its slot with errors
  function automatic void write_digit(int unsigned at, int unsigned num, int unsigned len);
    bit ok;
    ok = (num < 10) && (num < (1 << len));
    for (int unsigned i = 0; i < len; i++)
      frame_q[at + i] = ok ? sym_e'((num >> i) & 1) : SYM_ERR;
  endfunction

  function automatic void load_time(in_item_t it);
    int unsigned hr, mi, se, yr, mo, dy, doy, sod;
    hr = it.hour;
    mi = it.minute;
    se = it.second;
    yr = it.year;
    mo = it.month;
    dy = it.day;
    write_digit(1, se % 10, 4);
    write_digit(6, se / 10, 3);
    write_digit(10, mi % 10, 4);
    write_digit(15, mi / 10, 3);
    write_digit(20, hr % 10, 4);
    write_digit(25, hr / 10, 2);
    doy = dy + DaysBefore[mo];
    if (yr % 4 == 0 && mo > 2) doy++;
    write_digit(30, doy % 10, 4);
    write_digit(35, (doy % 100) / 10, 4);
    write_digit(40, doy / 100, 2);
    write_digit(50, yr % 10, 4);
    write_digit(55, (yr % 100) / 10, 4);
    // seconds of day, low 17 bits, skipping the marker at 89
    sod = hr * 3600 + mi * 60 + se;
    for (int unsigned i = 0; i < SodBits; i++)
      frame_q[(i < 9) ? 80 + i : 81 + i] = sym_e'((sod >> i) & 1);
  endfunction

  function automatic out_item_t play_tick();
    out_item_t   r;
    int unsigned highs;
    case (frame_q[sym_pos])
      SYM_ONE:  highs = 5;
      SYM_MARK: highs = 8;
      SYM_ERR:  highs = 10;
      default:  highs = 2;
    endcase
    r.level        = sub_pos < highs;
    r.symbol_start = sub_pos == 0;
    r.frame_end    = (sym_pos == FrameLen - 1) && (sub_pos == SubSlots - 1);
    if (frame_q[sym_pos] == SYM_ERR) n_err_slots++;
    if (r.frame_end) n_wraps++;
    sub_pos++;
    if (sub_pos == SubSlots) begin
      sub_pos = 0;
      sym_pos = (sym_pos + 1) % FrameLen;
    end
    return r;
  endfunction

  function automatic dir_row_t load_row(int h, int m, int s, int y, int mo, int d);
    dir_row_t row;
    row.item.op     = OP_LOAD;
    row.item.hour   = 6'(h);
    row.item.minute = 7'(m);
    row.item.second = 7'(s);
    row.item.year   = 14'(y);
    row.item.month  = 4'(mo);
    row.item.day    = 5'(d);
    row.typed       = 1'b0;
    row.want        = '0;
    return row;
  endfunction

  function automatic dir_row_t tick_row(bit typed, logic lvl, logic st, logic fe);
    dir_row_t row;
    row.item              = '0;
    row.item.op           = OP_TICK;
    row.typed             = typed;
    row.want.level        = lvl;
    row.want.symbol_start = st;
    row.want.frame_end    = fe;
    return row;
  endfunction

  // mostly plausible calendar times, some full-width noise; ticks carry junk fields
  function automatic in_item_t random_item();
    in_item_t it;
    if ($urandom_range(99) < 80) begin
      it.hour   = 6'($urandom_range(23));
      it.minute = 7'($urandom_range(59));
      it.second = 7'($urandom_range(59));
      it.year   = 14'($urandom_range(9999));
      it.month  = 4'($urandom_range(12, 1));
      it.day    = 5'($urandom_range(31, 1));
    end else begin
      it.hour   = 6'($urandom);
      it.minute = 7'($urandom);
      it.second = 7'($urandom);
      it.year   = 14'($urandom);
      it.month  = 4'($urandom);
      it.day    = 5'($urandom);
    end
    it.op = ($urandom_range(99) < 10) ? OP_LOAD : OP_TICK;
    return it;
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t hand_want);
    out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= it.op;
    hour_value_i   <= it.hour;
    minute_value_i <= it.minute;
    second_value_i <= it.second;
    year_value_i   <= it.year;
    month_value_i  <= it.month;
    day_value_i    <= it.day;
    do @(posedge clk_i); while (!in_ready_o);
    if (it.op == OP_LOAD) begin
      load_time(it);
      n_loads++;
    end else begin
      predicted = play_tick();
      slots_due.push_back(typed ? hand_want : predicted);
      n_ticks++;
    end
  endtask

  function automatic void report(string what);
    if (n_errors < MaxReports) $display("mismatch at cycle %0d: %s", cycles, what);
    n_errors++;
  endfunction

  // receiver, result check and watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timed out with %0d sub-slots outstanding", slots_due.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got.level        = level_o;
        got.symbol_start = symbol_start_o;
        got.frame_end    = frame_end_o;
        if (slots_due.size() == 0) begin
          report($sformatf("unexpected sub-slot level %b start %b end %b",
                           got.level, got.symbol_start, got.frame_end));
        end else begin
          want = slots_due.pop_front();
          if (got.level !== want.level)
            report($sformatf("level exp %b got %b", want.level, got.level));
          if (got.symbol_start !== want.symbol_start)
            report($sformatf("symbol_start exp %b got %b", want.symbol_start,
                             got.symbol_start));
          if (got.frame_end !== want.frame_end)
            report($sformatf("frame_end exp %b got %b", want.frame_end, got.frame_end));
        end
      end
    end
  end

  initial begin
    dir_row_t rows [$];
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    opcode_i       <= OP_TICK;
    hour_value_i   <= '0;
    minute_value_i <= '0;
    second_value_i <= '0;
    year_value_i   <= '0;
    month_value_i  <= '0;
    day_value_i    <= '0;
    out_ready_i    <= 1'b0;
    send_idle_pct  = 17;
    recv_idle_pct  = 73;
    frame_reset();

    // play starts on the marker at symbol 0
    rows.push_back(tick_row(1'b1, 1'b1, 1'b1, 1'b0));
    rows.push_back(tick_row(1'b1, 1'b1, 1'b0, 1'b0));
    // every field at its widest: tens of seconds, minutes and hours overflow
    rows.push_back(load_row(63, 127, 127, 16383, 15, 31));
    // month zero, day zero, year zero
    rows.push_back(load_row(0, 0, 0, 0, 0, 0));
    // leap year, january then march
    rows.push_back(load_row(12, 34, 56, 2024, 1, 1));
    rows.push_back(load_row(12, 34, 56, 2024, 3, 1));
    // month past twelve in a leap year
    rows.push_back(load_row(23, 59, 59, 2000, 13, 0));
    rows.push_back(load_row(23, 59, 59, 9999, 12, 31));
    // tens of hours and of seconds too wide, tens of minutes just fits
    rows.push_back(load_row(40, 60, 80, 1999, 2, 29));
    rows.push_back(load_row(29, 70, 79, 9998, 14, 15));
    // loads left the play position alone: rest of the marker
    repeat (6) rows.push_back(tick_row(1'b1, 1'b1, 1'b0, 1'b0));
    repeat (2) rows.push_back(tick_row(1'b1, 1'b0, 1'b0, 1'b0));
    repeat (3) rows.push_back(tick_row(1'b0, 1'b0, 1'b0, 1'b0));
    rows.push_back(load_row(9, 9, 9, 1, 11, 30));
    rows.push_back(tick_row(1'b0, 1'b0, 1'b0, 1'b0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 17; recv_idle_pct = 73; end
        1: begin send_idle_pct = 73; recv_idle_pct = 17; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      repeat (PhaseItems) send_item(random_item(), 1'b0, '0);
      // hold the sender until every owed sub-slot is back
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (slots_due.size() != 0);
    end
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered %0d loads and %0d ticks, %0d frame wraps, %0d error sub-slots played",
             n_loads, n_ticks, n_wraps, n_err_slots);
    $display("idle patterns: sender-light/receiver-heavy, the reverse, then none; %0d mismatches",
             n_errors);
    if (n_errors == 0 && slots_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
design/irig_pkg.sv
design/irig_calc_front.sv
design/irig_calc_back.sv
design/irig_frame.sv
design/irig_player.sv
design/irig_b_frame_generator.sv
design/irig_checker.sv
dv/tb_irig_b_frame_generator.sv
